// ===== rtl/multi_queue_command_deque_defines.svh =====
// ----------------------------------------------------------------------------
// multi_queue_command_deque assertion macros
// shared property forms for the checker files of the command deque
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_COMMAND_DEQUE_DEFINES_SVH
`define MULTI_QUEUE_COMMAND_DEQUE_DEFINES_SVH

// same-cycle implication
`define MQD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MQD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mqd_pkg.sv =====
// ----------------------------------------------------------------------------
// mqd_pkg
// shared codes, widths and controller/datapath bundles of the command deque
// ----------------------------------------------------------------------------
package mqd_pkg;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int QID_W    = 2;
  localparam int STATUS_W = 2;
  localparam int MASK_W   = 4;
  localparam int TOTAL_W  = 7;

  // operation codes, query and unknown codes only report
  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
  localparam logic [OP_W-1:0] OP_REQUEUE = 3'd2;
  localparam logic [OP_W-1:0] OP_FLUSH   = 3'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STS_EMPTY   = 2'd3;

  // register word index
  localparam logic REG_QUEUES_IN_USE = 1'b0;
  localparam logic REG_EVENT_ENABLE  = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_RESULT   = 4'b0010,
    S_FL_SEEK  = 4'b0100,
    S_FL_EMIT  = 4'b1000
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic load_single;
    logic fl_read;
    logic fl_emit;
    logic fl_next_q;
    logic fl_clear;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_flush;
    logic flush_empty;
    logic out_free;
    logic fl_q_has;
    logic fl_last_entry;
    logic fl_more;
  } dp_stat_t;

endpackage

// ===== rtl/mqd_regs.sv =====
// ----------------------------------------------------------------------------
// mqd_regs
// apb configuration registers: queues in use and event enable
// ----------------------------------------------------------------------------
module mqd_regs import mqd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [2:0]  queues_in_use,
  output logic        event_enable
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      queues_in_use <= '0;
      event_enable  <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_QUEUES_IN_USE: queues_in_use <= pwdata[2:0];
        REG_EVENT_ENABLE:  event_enable  <= pwdata[0];
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[2])
      REG_QUEUES_IN_USE: prdata = {29'd0, queues_in_use};
      REG_EVENT_ENABLE:  prdata = {31'd0, event_enable};
    endcase
  end

endmodule

// ===== rtl/mqd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mqd_ctrl
// sequencer: accepts one request, then emits its single result or walks flush
// ----------------------------------------------------------------------------
module mqd_ctrl import mqd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.is_flush && !stat.flush_empty) begin
            state_next = S_FL_SEEK;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      // skip empty and inactive queues, read the next handle of a filled one
      S_FL_SEEK: begin
        if (stat.fl_q_has) begin
          cmd.fl_read = 1'b1;
          state_next  = S_FL_EMIT;
        end else begin
          cmd.fl_next_q = 1'b1;
        end
      end
      S_FL_EMIT: begin
        if (stat.out_free) begin
          cmd.fl_emit = 1'b1;
          if (stat.fl_last_entry && !stat.fl_more) begin
            cmd.fl_clear = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.fl_next_q = stat.fl_last_entry;
            state_next    = S_FL_SEEK;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/mqd_dp.sv =====
// ----------------------------------------------------------------------------
// mqd_dp
// queue pointers, counts, running totals, handle memory and result register
// ----------------------------------------------------------------------------
module mqd_dp import mqd_pkg::*; #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic [OP_W-1:0]        in_op,
  input  logic [QID_W-1:0]       in_queue_id,
  input  logic [HANDLE_BITS-1:0] in_cmd_handle,
  input  logic                   in_handle_present,
  input  logic [2:0]             queues_in_use,
  input  logic                   event_enable,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    out_status,
  output logic [HANDLE_BITS-1:0] out_handle,
  output logic                   out_handle_valid,
  output logic [MASK_W-1:0]      out_mask,
  output logic [TOTAL_W-1:0]     out_total,
  output logic                   out_event,
  output logic                   out_last
);

  localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int IW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int NW        = $clog2(NUM_QUEUES + 1);
  localparam int AW        = QW + IW;
  localparam int MEM_DEPTH = 2 ** AW;

  // per-queue state
  logic [CW-1:0]      count  [NUM_QUEUES];
  logic [IW-1:0]      head   [NUM_QUEUES];
  // prefix[k] holds the entry sum of queues below k, modulo the total width
  logic [TOTAL_W-1:0] prefix [NUM_QUEUES+1];

  logic [HANDLE_BITS-1:0] mem [MEM_DEPTH];
  logic [HANDLE_BITS-1:0] rd_data;

  // flush walk position
  logic [QW-1:0] fq;
  logic [IW-1:0] fj;

  // single result held until the output register frees up
  logic [STATUS_W-1:0] res_status;
  logic                res_valid;
  logic                res_event;

  logic [4:0]          q_wrap;
  logic [QW-1:0]       q_in;
  logic [4:0]          n_wide;
  logic [NW-1:0]       n_eff;
  logic [NUM_QUEUES-1:0] active, nz, nz_act;
  logic [NUM_QUEUES+MASK_W-1:0] mask_pad;
  logic [MASK_W-1:0]   mask_now;
  logic [TOTAL_W-1:0]  pn;
  logic                fl_more;

  logic [QW-1:0]       rq;
  logic [CW-1:0]       cnt_r;
  logic [IW-1:0]       hd_r;
  logic                is_enq, is_deq, is_req, is_fl;
  logic                q_full, q_empty, ins_ok, deq_ok;
  logic [STATUS_W-1:0] status_c;
  logic [IW:0]         tail_sum, fl_sum;
  logic [IW-1:0]       tail_idx, fl_idx, hd_dec, hd_inc;

  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;

  // queue number modulo the queue count
  always_comb begin
    q_wrap = {3'd0, in_queue_id};
    for (int s = 0; s < 3; s++) begin
      if (q_wrap >= 5'(NUM_QUEUES)) q_wrap = q_wrap - 5'(NUM_QUEUES);
    end
  end
  assign q_in = q_wrap[QW-1:0];

  // active queue count, saturated
  assign n_wide = ({2'd0, queues_in_use} > 5'(NUM_QUEUES)) ? 5'(NUM_QUEUES)
                                                           : {2'd0, queues_in_use};
  assign n_eff  = n_wide[NW-1:0];
  assign pn     = prefix[n_eff];

  // per-queue flags, mask and remaining-queue search for flush
  always_comb begin
    fl_more = 1'b0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      active[i] = (5'(i) < n_wide);
      nz[i]     = (count[i] != '0);
      nz_act[i] = active[i] & nz[i];
      if (nz_act[i] && (i > int'(fq))) fl_more = 1'b1;
    end
  end
  assign mask_pad = {{MASK_W{1'b0}}, nz_act};
  assign mask_now = mask_pad[MASK_W-1:0];

  // op decode, query and unknown codes set nothing
  always_comb begin
    is_enq = 1'b0;
    is_deq = 1'b0;
    is_req = 1'b0;
    is_fl  = 1'b0;
    case (in_op)
      OP_ENQUEUE: is_enq = 1'b1;
      OP_DEQUEUE: is_deq = 1'b1;
      OP_REQUEUE: is_req = 1'b1;
      OP_FLUSH:   is_fl  = 1'b1;
      default:    ;
    endcase
  end

  // one count/head read port, shared by the request and the flush walk
  assign rq    = cmd.accept ? q_in : fq;
  assign cnt_r = count[rq];
  assign hd_r  = head[rq];

  assign q_full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign ins_ok  = (is_enq | is_req) & in_handle_present & ~q_full;
  assign deq_ok  = is_deq & ~q_empty;

  // missing handle is checked before fullness
  always_comb begin
    status_c = STS_OK;
    if (is_enq || is_req) begin
      if (!in_handle_present) status_c = STS_MISSING;
      else if (q_full)        status_c = STS_FULL;
    end else if (is_deq && q_empty) begin
      status_c = STS_EMPTY;
    end
  end

  // ring index arithmetic
  always_comb begin
    tail_sum = (IW+1)'(hd_r) + (IW+1)'(cnt_r);
    if (tail_sum >= (IW+1)'(QUEUE_DEPTH)) tail_sum = tail_sum - (IW+1)'(QUEUE_DEPTH);
    fl_sum = (IW+1)'(hd_r) + (IW+1)'(fj);
    if (fl_sum >= (IW+1)'(QUEUE_DEPTH)) fl_sum = fl_sum - (IW+1)'(QUEUE_DEPTH);
  end
  assign tail_idx = tail_sum[IW-1:0];
  assign fl_idx   = fl_sum[IW-1:0];
  assign hd_dec   = (hd_r == '0) ? IW'(QUEUE_DEPTH - 1) : hd_r - IW'(1);
  assign hd_inc   = (hd_r == IW'(QUEUE_DEPTH - 1)) ? '0 : hd_r + IW'(1);

  // handle memory
  assign wr_en   = cmd.accept & ins_ok;
  assign wr_addr = {q_in, (is_enq ? tail_idx : hd_dec)};
  assign rd_en   = (cmd.accept & deq_ok) | cmd.fl_read;
  assign rd_addr = cmd.fl_read ? {fq, fl_idx} : {q_in, hd_r};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_cmd_handle;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // counts and heads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        count[i] <= '0;
        head[i]  <= '0;
      end
    end else begin
      if (cmd.accept && ins_ok) begin
        count[q_in] <= cnt_r + CW'(1);
        if (is_req) head[q_in] <= hd_dec;
      end
      if (cmd.accept && deq_ok) begin
        count[q_in] <= cnt_r - CW'(1);
        head[q_in]  <= hd_inc;
      end
      if (cmd.fl_clear) begin
        for (int i = 0; i < NUM_QUEUES; i++) begin
          if (active[i]) begin
            count[i] <= '0;
            head[i]  <= '0;
          end
        end
      end
    end
  end

  // running prefix totals
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NUM_QUEUES; k++) prefix[k] <= '0;
    end else if (cmd.accept) begin
      for (int k = 0; k <= NUM_QUEUES; k++) begin
        if (ins_ok && (k > int'(q_in)))      prefix[k] <= prefix[k] + TOTAL_W'(1);
        else if (deq_ok && (k > int'(q_in))) prefix[k] <= prefix[k] - TOTAL_W'(1);
        else if (is_fl) begin
          if (k <= int'(n_eff)) prefix[k] <= '0;
          else                  prefix[k] <= prefix[k] - pn;
        end
      end
    end
  end

  // flush walk position
  always_ff @(posedge clk) begin
    if (rst) begin
      fq <= '0;
      fj <= '0;
    end else if (cmd.accept) begin
      fq <= '0;
      fj <= '0;
    end else if (cmd.fl_next_q) begin
      fq <= fq + QW'(1);
      fj <= '0;
    end else if (cmd.fl_emit) begin
      fj <= fj + IW'(1);
    end
  end

  // single result capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status <= status_c;
      res_valid  <= deq_ok;
      res_event  <= is_enq & ins_ok & q_empty & event_enable;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_single || cmd.fl_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      out_status       <= res_status;
      out_handle       <= res_valid ? rd_data : '0;
      out_handle_valid <= res_valid;
      out_mask         <= mask_now;
      out_total        <= pn;
      out_event        <= res_event;
      out_last         <= 1'b1;
    end else if (cmd.fl_emit) begin
      // every flush result reports the drained state
      out_status       <= STS_OK;
      out_handle       <= rd_data;
      out_handle_valid <= 1'b1;
      out_mask         <= '0;
      out_total        <= '0;
      out_event        <= 1'b0;
      out_last         <= stat.fl_last_entry & ~fl_more;
    end
  end

  // status to the controller
  assign stat.is_flush      = is_fl;
  assign stat.flush_empty   = ~(|nz_act);
  assign stat.out_free      = ~out_valid | out_ready;
  assign stat.fl_q_has      = active[fq] & ~q_empty;
  assign stat.fl_last_entry = ((CW'(fj) + CW'(1)) == cnt_r);
  assign stat.fl_more       = fl_more;

endmodule

// ===== rtl/multi_queue_command_deque.sv =====
// A non-flush request is accepted in the idle state; its result is captured and is
//   loaded into the output register once free, before a new request is taken.
// Flush: handles are read one at a time through the single handle memory read port
//   and emitted, empty queues are skipped, and an empty flush gives one result.
// Reset: counts, heads, running totals, configuration and output valid clear;
//   handle storage is not cleared.
// ----------------------------------------------------------------------------
// multi_queue_command_deque
// per-channel command handle queues with tail enqueue, head requeue, head
// dequeue and a flush that releases, from the active queues, every queued handle
// ----------------------------------------------------------------------------
module multi_queue_command_deque import mqd_pkg::*; #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // queue_id, cmd_handle, handle_present
  input  logic [((HANDLE_BITS+10)/8)*8-1:0] s_tdata,
  // op
  input  logic [OP_W-1:0] s_tuser,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_handle, handle_valid, nonempty_mask, total_queued, new_command_event
  output logic [((HANDLE_BITS+20)/8)*8-1:0] m_tdata,
  // status
  output logic [STATUS_W-1:0] m_tuser,
  output logic        m_tlast
);

  localparam int OUT_W = ((HANDLE_BITS + 20) / 8) * 8;
  localparam int RES_W = HANDLE_BITS + 1 + MASK_W + TOTAL_W + 1;

  logic [2:0]             queues_in_use;
  logic                   event_enable;
  dp_cmd_t                cmd;
  dp_stat_t               stat;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   out_handle_valid;
  logic [MASK_W-1:0]      out_mask;
  logic [TOTAL_W-1:0]     out_total;
  logic                   out_event;

  // configuration registers
  mqd_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .queues_in_use (queues_in_use),
    .event_enable  (event_enable)
  );

  // sequencer
  mqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // queue datapath
  mqd_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (s_tuser),
    .in_queue_id       (s_tdata[QID_W-1:0]),
    .in_cmd_handle     (s_tdata[QID_W+HANDLE_BITS-1:QID_W]),
    .in_handle_present (s_tdata[QID_W+HANDLE_BITS]),
    .queues_in_use     (queues_in_use),
    .event_enable      (event_enable),
    .out_ready         (m_tready),
    .out_valid         (m_tvalid),
    .out_status        (m_tuser),
    .out_handle        (out_handle),
    .out_handle_valid  (out_handle_valid),
    .out_mask          (out_mask),
    .out_total         (out_total),
    .out_event         (out_event),
    .out_last          (m_tlast)
  );

  // result packing, zero filled to whole bytes
  assign m_tdata = OUT_W'(RES_W'({out_event, out_total, out_mask,
                                  out_handle_valid, out_handle}));

endmodule

// ===== rtl/mqd_checker.sv =====
// ----------------------------------------------------------------------------
// mqd_checker
// port-level checks on the result stream of the command deque
// ----------------------------------------------------------------------------
`include "multi_queue_command_deque_defines.svh"

module mqd_checker import mqd_pkg::*; #(
  parameter int HANDLE_BITS = 16
) (
  input logic clk,
  input logic rst,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((HANDLE_BITS+20)/8)*8-1:0] m_tdata,
  input logic [STATUS_W-1:0] m_tuser,
  input logic m_tlast
);

  logic hv;
  logic ev;

  assign hv = m_tdata[HANDLE_BITS];
  assign ev = m_tdata[HANDLE_BITS+1+MASK_W+TOTAL_W];

  // no result straight after reset
  `MQD_ASSERT_NXT(a_reset_idle, clk, 1'b0, rst, !m_tvalid, "result valid after reset")

  // a stalled result holds
  `MQD_ASSERT_NXT(a_stall_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
    "stalled result changed")

  // no handle means a zero handle field
  `MQD_ASSERT_IMP(a_handle_zero, clk, rst, m_tvalid && !hv,
    m_tdata[HANDLE_BITS-1:0] == '0, "handle field set without a handle")

  // an error result is a single, handle-free, event-free result
  `MQD_ASSERT_IMP(a_error_single, clk, rst, m_tvalid && (m_tuser != STS_OK),
    m_tlast && !hv && !ev, "error result carries handle, event or no last")

endmodule

bind multi_queue_command_deque mqd_checker #(.HANDLE_BITS(HANDLE_BITS)) u_mqd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
